@@ rtl/core/scheduled_relay_controller_defines.svh @@
// assertion macros shared by the scheduled relay controller rtl
`ifndef SCHEDULED_RELAY_CONTROLLER_DEFINES_SVH
`define SCHEDULED_RELAY_CONTROLLER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SRCTL_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("srctl: same-cycle check failed");

// condition holds in the cycle after the trigger
`define SRCTL_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("srctl: next-cycle check failed");

`endif

@@ rtl/core/srctl_pkg.sv @@
// package: codes, widths and sequencer states of the scheduled relay controller
`default_nettype none
package srctl_pkg;

  // field widths
  localparam int unsigned TimeW = 17;
  localparam int unsigned ModeW = 3;

  // length of one day in seconds
  localparam logic [TimeW:0] SECONDS_PER_DAY = (TimeW + 1)'(86400);

  // operating modes
  localparam logic [ModeW-1:0] MODE_NONE   = 3'd0;
  localparam logic [ModeW-1:0] MODE_COND   = 3'd1;
  localparam logic [ModeW-1:0] MODE_LOOP   = 3'd2;
  localparam logic [ModeW-1:0] MODE_WINDOW = 3'd3;
  localparam logic [ModeW-1:0] MODE_MANUAL = 3'd4;

  // relay commands
  localparam logic [1:0] CMD_OFF  = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_HOLD = 2'd2;

  // fault codes
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_OVERTIME = 2'd1;
  localparam logic [1:0] FAULT_COND     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MODE          = 3'd0;
  localparam logic [2:0] REG_WINDOW_START  = 3'd1;
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd2;
  localparam logic [2:0] REG_LOOP_ON       = 3'd3;
  localparam logic [2:0] REG_LOOP_OFF      = 3'd4;
  localparam logic [2:0] REG_MAX_ON        = 3'd5;
  localparam logic [2:0] REG_MIN_ON        = 3'd6;
  localparam logic [2:0] REG_FAULT_HOLD    = 3'd7;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_CHK,
    S_COND,
    S_LOOP_LD,
    S_DIV,
    S_LOOP_END,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/scheduled_relay_controller.sv @@
// scheduled relay controller: window check, condition timers, bit-serial loop modulo
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in_     | input     | in_valid/in_stall  | now, on/off/fault cond, manual, ...
//   out_    | output    | out_valid/out_stall| command, fault_code
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a tick runs from accept through the window and check states to done; condition mode adds
// the condition state, loop mode the load, divide and end states, where the remainder
// is built one dividend bit per cycle. a new beat is taken only in idle; the result
// register lets the next beat in while a result still waits under out_stall.
// rst_n is synchronous; cfg_ready is always high.
`default_nettype none
`include "scheduled_relay_controller_defines.svh"
module scheduled_relay_controller (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [srctl_pkg::TimeW-1:0] in_now,
  input  wire logic                       in_on_cond,
  input  wire logic                       in_off_cond,
  input  wire logic                       in_fault_cond,
  input  wire logic                       in_manual_on,
  input  wire logic                       in_force_reset,
  input  wire logic                       in_ignore_max,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_command,
  output logic [1:0]                      out_fault_code,
  // configuration channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [srctl_pkg::TimeW-1:0] cfg_data
);

  localparam int unsigned TW = srctl_pkg::TimeW;
  localparam int unsigned CntW = $clog2(TW + 1);

  srctl_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [srctl_pkg::ModeW-1:0] mode_r, mode_nxt;
  logic [TW-1:0] win_start_r, win_start_nxt;
  logic [TW-1:0] win_len_r, win_len_nxt;
  logic [TW-1:0] loop_on_r, loop_on_nxt;
  logic [TW-1:0] loop_off_r, loop_off_nxt;
  logic [TW-1:0] max_on_r, max_on_nxt;
  logic [TW-1:0] min_on_r, min_on_nxt;
  logic [TW-1:0] hold_r, hold_nxt;

  // controller state
  logic [srctl_pkg::ModeW-1:0] last_mode_r, last_mode_nxt;
  logic          relay_on_r, relay_on_nxt;
  logic [TW-1:0] on_since_r, on_since_nxt;
  logic          latched_r, latched_nxt;
  logic [TW-1:0] fault_since_r, fault_since_nxt;
  logic [1:0]    reason_r, reason_nxt;

  // captured beat
  logic [TW-1:0] now_r, now_nxt;
  logic on_c_r, on_c_nxt, off_c_r, off_c_nxt, fault_c_r, fault_c_nxt;
  logic manual_r, manual_nxt, force_r, force_nxt, ign_max_r, ign_max_nxt;

  // work registers
  logic [TW:0]   end_r, end_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [TW-1:0] div_r, div_nxt;
  logic [TW:0]   rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_cmd_r, out_cmd_nxt;
  logic [1:0] out_fc_r, out_fc_nxt;

  // shared arithmetic
  logic [TW:0]   now18, start18, stop18, period;
  logic          wrap;
  logic [TW:0]   d_on, d_fault, ad;
  logic [TW+1:0] shifted, trial;

  assign now18   = {1'b0, now_r};
  assign start18 = {1'b0, win_start_r};
  assign wrap    = end_r > srctl_pkg::SECONDS_PER_DAY;
  assign stop18  = end_r - srctl_pkg::SECONDS_PER_DAY;
  assign period  = {1'b0, loop_on_r} + {1'b0, loop_off_r};
  assign d_on    = now18 - {1'b0, on_since_r};
  assign d_fault = now18 - {1'b0, fault_since_r};
  assign ad      = d_on[TW] ? (~d_on + (TW + 1)'(1)) : d_on;
  assign shifted = {rem_r, div_r[TW-1]};
  assign trial   = shifted - {1'b0, period};

  assign in_stall       = (state_r != srctl_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_command    = out_cmd_r;
  assign out_fault_code = out_fc_r;
  assign cfg_ready      = 1'b1;

  // sequencer, configuration writes and result register
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    win_start_nxt   = win_start_r;
    win_len_nxt     = win_len_r;
    loop_on_nxt     = loop_on_r;
    loop_off_nxt    = loop_off_r;
    max_on_nxt      = max_on_r;
    min_on_nxt      = min_on_r;
    hold_nxt        = hold_r;
    last_mode_nxt   = last_mode_r;
    relay_on_nxt    = relay_on_r;
    on_since_nxt    = on_since_r;
    latched_nxt     = latched_r;
    fault_since_nxt = fault_since_r;
    reason_nxt      = reason_r;
    now_nxt         = now_r;
    on_c_nxt        = on_c_r;
    off_c_nxt       = off_c_r;
    fault_c_nxt     = fault_c_r;
    manual_nxt      = manual_r;
    force_nxt       = force_r;
    ign_max_nxt     = ign_max_r;
    end_nxt         = end_r;
    cmd_nxt         = cmd_r;
    div_nxt         = div_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    out_cmd_nxt     = out_cmd_r;
    out_fc_nxt      = out_fc_r;

    // configuration write
    if (cfg_valid) begin
      unique case (cfg_index)
        srctl_pkg::REG_MODE:          mode_nxt      = cfg_data[srctl_pkg::ModeW-1:0];
        srctl_pkg::REG_WINDOW_START:  win_start_nxt = cfg_data;
        srctl_pkg::REG_WINDOW_LENGTH: win_len_nxt   = cfg_data;
        srctl_pkg::REG_LOOP_ON:       loop_on_nxt   = cfg_data;
        srctl_pkg::REG_LOOP_OFF:      loop_off_nxt  = cfg_data;
        srctl_pkg::REG_MAX_ON:        max_on_nxt    = cfg_data;
        srctl_pkg::REG_MIN_ON:        min_on_nxt    = cfg_data;
        srctl_pkg::REG_FAULT_HOLD:    hold_nxt      = cfg_data;
        default: ;
      endcase
    end

    // result beat taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      srctl_pkg::S_IDLE: begin
        if (in_valid) begin
          now_nxt     = in_now;
          on_c_nxt    = in_on_cond;
          off_c_nxt   = in_off_cond;
          fault_c_nxt = in_fault_cond;
          manual_nxt  = in_manual_on;
          force_nxt   = in_force_reset;
          ign_max_nxt = in_ignore_max;
          state_nxt   = srctl_pkg::S_WIN;
        end
      end

      // window end, may pass midnight
      srctl_pkg::S_WIN: begin
        end_nxt   = {1'b0, win_start_r} + {1'b0, win_len_r};
        state_nxt = srctl_pkg::S_CHK;
      end

      // manual level, window test, timer clear on mode change, forced reset or outside a non-wrapping window
      srctl_pkg::S_CHK: begin
        state_nxt = srctl_pkg::S_DONE;
        if (mode_r == srctl_pkg::MODE_MANUAL) begin
          cmd_nxt = manual_r ? srctl_pkg::CMD_ON : srctl_pkg::CMD_OFF;
        end else if (wrap && !(now18 < stop18 || now18 > start18)) begin
          cmd_nxt = srctl_pkg::CMD_OFF;
        end else if (!wrap && (now18 < start18 || now18 > end_r)) begin
          latched_nxt     = 1'b0;
          fault_since_nxt = now_r;
          relay_on_nxt    = 1'b1;
          on_since_nxt    = now_r;
          cmd_nxt         = srctl_pkg::CMD_OFF;
        end else begin
          if (mode_r != last_mode_r || force_r) begin
            last_mode_nxt = mode_r;
            if (mode_r == srctl_pkg::MODE_COND) begin
              reason_nxt = srctl_pkg::FAULT_NONE;
            end
            latched_nxt     = 1'b0;
            fault_since_nxt = now_r;
            relay_on_nxt    = 1'b0;
            on_since_nxt    = now_r;
          end
          unique case (mode_r)
            srctl_pkg::MODE_NONE:   cmd_nxt = srctl_pkg::CMD_OFF;
            srctl_pkg::MODE_COND:   state_nxt = srctl_pkg::S_COND;
            srctl_pkg::MODE_LOOP:   state_nxt = srctl_pkg::S_LOOP_LD;
            srctl_pkg::MODE_WINDOW: cmd_nxt = srctl_pkg::CMD_ON;
            default:                cmd_nxt = srctl_pkg::CMD_HOLD;
          endcase
        end
      end

      // condition mode: fault latch, min and max on time
      srctl_pkg::S_COND: begin
        state_nxt = srctl_pkg::S_DONE;
        cmd_nxt   = srctl_pkg::CMD_HOLD;
        if (latched_r) begin
          if ($signed(d_fault) > $signed({1'b0, hold_r})) begin
            latched_nxt = 1'b0;
            reason_nxt  = srctl_pkg::FAULT_NONE;
          end
        end else if (fault_c_r) begin
          reason_nxt      = srctl_pkg::FAULT_COND;
          fault_since_nxt = now_r;
          latched_nxt     = 1'b1;
          relay_on_nxt    = 1'b0;
          cmd_nxt         = srctl_pkg::CMD_OFF;
        end else if (relay_on_r) begin
          if ($signed(d_on) > $signed({1'b0, max_on_r}) && !ign_max_r) begin
            reason_nxt      = srctl_pkg::FAULT_OVERTIME;
            fault_since_nxt = now_r;
            latched_nxt     = 1'b1;
            relay_on_nxt    = 1'b0;
            cmd_nxt         = srctl_pkg::CMD_OFF;
          end else if (off_c_r && $signed(d_on) > $signed({1'b0, min_on_r})) begin
            relay_on_nxt = 1'b0;
            cmd_nxt      = srctl_pkg::CMD_OFF;
          end
        end else if (on_c_r) begin
          relay_on_nxt = 1'b1;
          on_since_nxt = now_r;
          cmd_nxt      = srctl_pkg::CMD_ON;
        end
      end

      // loop mode: load magnitude of elapsed time into the dividend shifter
      srctl_pkg::S_LOOP_LD: begin
        div_nxt   = ad[TW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = CntW'(TW);
        state_nxt = srctl_pkg::S_DIV;
      end

      // restoring remainder, one dividend bit per cycle; a zero period keeps it at zero
      srctl_pkg::S_DIV: begin
        if (period == '0) begin
          rem_nxt = '0;
        end else if (!trial[TW+1]) begin
          rem_nxt = trial[TW:0];
        end else begin
          rem_nxt = shifted[TW:0];
        end
        div_nxt = {div_r[TW-2:0], 1'b0};
        cnt_nxt = cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          state_nxt = srctl_pkg::S_LOOP_END;
        end
      end

      // on part of the period
      srctl_pkg::S_LOOP_END: begin
        cmd_nxt   = (rem_r <= {1'b0, loop_on_r}) ? srctl_pkg::CMD_ON : srctl_pkg::CMD_OFF;
        state_nxt = srctl_pkg::S_DONE;
      end

      // hand the result to the output register once it is free
      srctl_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cmd_nxt   = cmd_r;
          out_fc_nxt    = reason_r;
          state_nxt     = srctl_pkg::S_IDLE;
        end
      end

      default: state_nxt = srctl_pkg::S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= srctl_pkg::S_IDLE;
      out_valid_r   <= 1'b0;
      mode_r        <= srctl_pkg::MODE_NONE;
      win_start_r   <= '0;
      win_len_r     <= '0;
      loop_on_r     <= '0;
      loop_off_r    <= TW'(1);
      max_on_r      <= '0;
      min_on_r      <= '0;
      hold_r        <= '0;
      last_mode_r   <= srctl_pkg::MODE_NONE;
      relay_on_r    <= 1'b0;
      on_since_r    <= '0;
      latched_r     <= 1'b0;
      fault_since_r <= '0;
      reason_r      <= srctl_pkg::FAULT_NONE;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      mode_r        <= mode_nxt;
      win_start_r   <= win_start_nxt;
      win_len_r     <= win_len_nxt;
      loop_on_r     <= loop_on_nxt;
      loop_off_r    <= loop_off_nxt;
      max_on_r      <= max_on_nxt;
      min_on_r      <= min_on_nxt;
      hold_r        <= hold_nxt;
      last_mode_r   <= last_mode_nxt;
      relay_on_r    <= relay_on_nxt;
      on_since_r    <= on_since_nxt;
      latched_r     <= latched_nxt;
      fault_since_r <= fault_since_nxt;
      reason_r      <= reason_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    on_c_r    <= on_c_nxt;
    off_c_r   <= off_c_nxt;
    fault_c_r <= fault_c_nxt;
    manual_r  <= manual_nxt;
    force_r   <= force_nxt;
    ign_max_r <= ign_max_nxt;
    end_r     <= end_nxt;
    cmd_r     <= cmd_nxt;
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    out_cmd_r <= out_cmd_nxt;
    out_fc_r  <= out_fc_nxt;
  end

  // checks
  `SRCTL_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != srctl_pkg::S_IDLE)
  `SRCTL_ASSERT_SAME(a_latch_relay_off, latched_r, !relay_on_r)
  `SRCTL_ASSERT_SAME(a_rem_reduced, state_r == srctl_pkg::S_LOOP_END, rem_r < period || rem_r == '0)
  `SRCTL_ASSERT_SAME(a_div_count_live, state_r == srctl_pkg::S_DIV, cnt_r != '0)

endmodule
`default_nettype wire
